// File: rtl/i2c_bit_level_master_assert.svh
// assertion macros for the i2c bit level master
`ifndef I2C_BIT_LEVEL_MASTER_ASSERT_SVH
`define I2C_BIT_LEVEL_MASTER_ASSERT_SVH

// checked only out of reset
`define I2C_BLM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define I2C_BLM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/i2c_blm_pkg.sv
`timescale 1ns / 1ps

package i2c_blm_pkg;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_e;

  localparam int unsigned NumBits = 8;
  localparam logic [3:0] BitsDone = 4'(NumBits);
  localparam logic [15:0] HalfPeriodReset = 16'd2;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_seen;
  } res_t;

endpackage

// File: rtl/i2c_blm_in_if.sv
`timescale 1ns / 1ps

interface i2c_blm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [7:0] write_data;
  logic       sda_in;

  modport source (output valid, opcode, write_data, sda_in, input ready);
  modport sink (input valid, opcode, write_data, sda_in, output ready);
endinterface

// File: rtl/i2c_blm_out_if.sv
`timescale 1ns / 1ps

interface i2c_blm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_byte;
  logic       ack_seen;

  modport source (output valid, scl_level, sda_level, busy_res, done_res, read_byte,
                  ack_seen, input ready);
  modport sink (input valid, scl_level, sda_level, busy_res, done_res, read_byte,
                ack_seen, output ready);
endinterface

// File: rtl/i2c_bit_level_master.sv
// result: the result beat of a tick is registered and presented in the cycle after the tick is accepted
// throughput: one tick per cycle; the result register frees in the cycle it is taken,
//   so the only stall comes from the result side holding ready low
// reset (async, active low): idle, scl and sda released, read byte and ack cleared,
//   half period back to 2, no result pending
`timescale 1ns / 1ps

`include "i2c_bit_level_master_assert.svh"

module i2c_bit_level_master (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i,
  i2c_blm_in_if.sink           in_i,
  i2c_blm_out_if.source        out_o
);

  logic [15:0]              half_q;
  i2c_blm_pkg::cmd_e        cmd_q, cmd_d;
  logic [3:0]               phase_q, phase_d;
  logic [3:0]               bit_q, bit_d;
  logic [7:0]               shift_q, shift_d;
  logic [15:0]              wait_q, wait_d;
  logic                     scl_q, scl_d;
  logic                     sda_q, sda_d;
  logic [7:0]               rbyte_q, rbyte_d;
  logic                     ack_q, ack_d;
  logic                     done;
  logic                     fin;
  logic [15:0]              half_eff;
  logic                     acc;
  logic                     out_valid_q;
  i2c_blm_pkg::res_t        res_q, res_d;
  logic                     is_idle;
  logic                     idle_zero;
  logic                     start_acc;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign acc        = in_i.valid && in_i.ready;
  assign half_eff   = (half_q == 16'd0) ? 16'd1 : half_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= i2c_blm_pkg::HalfPeriodReset;
    end else if (cfg_we_i) begin
      half_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    cmd_d   = cmd_q;
    phase_d = phase_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    wait_d  = wait_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    rbyte_d = rbyte_q;
    ack_d   = ack_q;
    done    = 1'b0;
    fin     = 1'b0;
    if (acc) begin
      if (cmd_q == i2c_blm_pkg::CMD_NONE) begin
        if (in_i.opcode inside {[i2c_blm_pkg::CMD_START:i2c_blm_pkg::CMD_READ]}) begin
          cmd_d   = i2c_blm_pkg::cmd_e'(in_i.opcode);
          phase_d = 4'd0;
          bit_d   = 4'd0;
          shift_d = (in_i.opcode == i2c_blm_pkg::CMD_WRITE) ? in_i.write_data : 8'd0;
          wait_d  = half_eff;
        end
      end else if (wait_q > 16'd1) begin
        wait_d = wait_q - 16'd1;
      end else begin
        case (cmd_q)
          i2c_blm_pkg::CMD_START: begin
            if (phase_q == 4'd0) begin
              sda_d = 1'b0; phase_d = 4'd1;
            end else begin
              scl_d = 1'b0; fin = 1'b1;
            end
          end
          i2c_blm_pkg::CMD_STOP: begin
            if (phase_q == 4'd0) begin
              sda_d = 1'b0; phase_d = 4'd1;
            end else if (phase_q == 4'd1) begin
              scl_d = 1'b1; phase_d = 4'd2;
            end else begin
              sda_d = 1'b1; fin = 1'b1;
            end
          end
          i2c_blm_pkg::CMD_WRITE: begin
            if (bit_q < i2c_blm_pkg::BitsDone) begin
              if (phase_q == 4'd0) begin
                // msb first: bit index 0 drives shift bit 7
                sda_d = shift_q[~bit_q[2:0]]; phase_d = 4'd1;
              end else if (phase_q == 4'd1) begin
                scl_d = 1'b1; phase_d = 4'd2;
              end else begin
                scl_d = 1'b0; phase_d = 4'd0; bit_d = bit_q + 4'd1;
              end
            end else if (phase_q == 4'd0) begin
              sda_d = 1'b1; phase_d = 4'd1;
            end else if (phase_q == 4'd1) begin
              scl_d = 1'b1; phase_d = 4'd2;
            end else begin
              ack_d = !in_i.sda_in; scl_d = 1'b0; fin = 1'b1;
            end
          end
          i2c_blm_pkg::CMD_READ: begin
            if (bit_q < i2c_blm_pkg::BitsDone) begin
              if (phase_q == 4'd0) begin
                scl_d = 1'b1; phase_d = 4'd1;
              end else begin
                shift_d = {shift_q[6:0], in_i.sda_in};
                scl_d = 1'b0; phase_d = 4'd0; bit_d = bit_q + 4'd1;
              end
            end else if (phase_q == 4'd0) begin
              sda_d = 1'b0; phase_d = 4'd1;
            end else if (phase_q == 4'd1) begin
              scl_d = 1'b1; phase_d = 4'd2;
            end else if (phase_q == 4'd2) begin
              scl_d = 1'b0; phase_d = 4'd3;
            end else begin
              sda_d = 1'b1; rbyte_d = shift_q; fin = 1'b1;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
        if (fin) begin
          cmd_d   = i2c_blm_pkg::CMD_NONE;
          phase_d = 4'd0;
          bit_d   = 4'd0;
          wait_d  = 16'd0;
          done    = 1'b1;
        end else begin
          wait_d = half_eff;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q   <= i2c_blm_pkg::CMD_NONE;
      phase_q <= 4'd0;
      bit_q   <= 4'd0;
      shift_q <= 8'd0;
      wait_q  <= 16'd0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      rbyte_q <= 8'd0;
      ack_q   <= 1'b0;
    end else begin
      cmd_q   <= cmd_d;
      phase_q <= phase_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      wait_q  <= wait_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      rbyte_q <= rbyte_d;
      ack_q   <= ack_d;
    end
  end

  // result beat shows the state left by the tick
  always_comb begin
    res_d.scl_level = scl_d;
    res_d.sda_level = sda_d;
    res_d.busy_res  = (cmd_d != i2c_blm_pkg::CMD_NONE);
    res_d.done_res  = done;
    res_d.read_byte = rbyte_d;
    res_d.ack_seen  = ack_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (acc) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.scl_level = res_q.scl_level;
  assign out_o.sda_level = res_q.sda_level;
  assign out_o.busy_res  = res_q.busy_res;
  assign out_o.done_res  = res_q.done_res;
  assign out_o.read_byte = res_q.read_byte;
  assign out_o.ack_seen  = res_q.ack_seen;

  assign is_idle   = (cmd_q == i2c_blm_pkg::CMD_NONE);
  assign idle_zero = (wait_q == 16'd0) && (phase_q == 4'd0) && (bit_q == 4'd0);
  assign start_acc = acc && is_idle && (in_i.opcode == i2c_blm_pkg::CMD_START);

  `I2C_BLM_ASSERT(a_done_not_busy, (out_valid_q && res_q.done_res) |-> !res_q.busy_res, "done with busy")
  `I2C_BLM_ASSERT_ALWAYS(a_idle_clean, is_idle |-> idle_zero, "idle state not clean")
  `I2C_BLM_ASSERT(a_bit_range, bit_q <= i2c_blm_pkg::BitsDone, "bit index out of range")
  `I2C_BLM_ASSERT(a_start_taken, start_acc |=> (cmd_q == i2c_blm_pkg::CMD_START && out_o.busy_res), "start not taken")

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned StallLimit = 4000;
  localparam int unsigned RandomTicks = 800;
  localparam int unsigned MaxShown = 10;
  localparam int unsigned LongHold = 300;
  localparam logic [2:0] OpFirstReserved = 3'd5;
  localparam int unsigned NumReserved = 3;

  typedef enum int unsigned {SDA_LOW, SDA_HIGH, SDA_RANDOM} sda_mode_e;
  typedef enum int unsigned {FILL_IDLE, FILL_NOISE, FILL_READ} fill_mode_e;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  i2c_blm_in_if  in_if ();
  i2c_blm_out_if out_if ();

  i2c_bit_level_master uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // bus model state
  logic [15:0]        bus_half;
  i2c_blm_pkg::cmd_e  bus_cmd;
  logic [3:0]         bus_phase;
  logic [3:0]         bus_bit;
  logic [7:0]         bus_shift;
  logic [15:0]        bus_wait;
  logic               bus_scl;
  logic               bus_sda;
  logic [7:0]         bus_rx;
  logic               bus_ack;

  i2c_blm_pkg::res_t  expected_beats[$];
  int unsigned bad_beats = 0;
  int unsigned stall_cycles = 0;
  int unsigned ticks_sent = 0;
  int unsigned sink_hold = 0;
  bit          calm = 1'b0;

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // advances the bus model by one tick and returns the beat it should produce
  function automatic i2c_blm_pkg::res_t advance_bus(input logic [2:0] op,
                                                    input logic [7:0] data,
                                                    input logic sda);
    logic [15:0]       step;
    logic              fin;
    i2c_blm_pkg::res_t r;
    step = (bus_half == 16'd0) ? 16'd1 : bus_half;
    fin = 1'b0;
    if (bus_cmd == i2c_blm_pkg::CMD_NONE) begin
      if (op >= i2c_blm_pkg::CMD_START && op <= i2c_blm_pkg::CMD_READ) begin
        bus_cmd = i2c_blm_pkg::cmd_e'(op);
        bus_phase = 4'd0;
        bus_bit = 4'd0;
        bus_shift = (op == i2c_blm_pkg::CMD_WRITE) ? data : 8'h00;
        bus_wait = step;
      end
    end else if (bus_wait > 16'd1) begin
      bus_wait--;
    end else begin
      case (bus_cmd)
        i2c_blm_pkg::CMD_START: begin
          if (bus_phase == 4'd0) begin
            bus_sda = 1'b0;
            bus_phase = 4'd1;
          end else begin
            bus_scl = 1'b0;
            fin = 1'b1;
          end
        end
        i2c_blm_pkg::CMD_STOP: begin
          if (bus_phase == 4'd0) begin
            bus_sda = 1'b0;
            bus_phase = 4'd1;
          end else if (bus_phase == 4'd1) begin
            bus_scl = 1'b1;
            bus_phase = 4'd2;
          end else begin
            bus_sda = 1'b1;
            fin = 1'b1;
          end
        end
        i2c_blm_pkg::CMD_WRITE: begin
          if (bus_bit < i2c_blm_pkg::BitsDone) begin
            if (bus_phase == 4'd0) begin
              bus_sda = bus_shift[3'd7 - bus_bit[2:0]];
              bus_phase = 4'd1;
            end else if (bus_phase == 4'd1) begin
              bus_scl = 1'b1;
              bus_phase = 4'd2;
            end else begin
              bus_scl = 1'b0;
              bus_phase = 4'd0;
              bus_bit++;
            end
          end else if (bus_phase == 4'd0) begin
            bus_sda = 1'b1;
            bus_phase = 4'd1;
          end else if (bus_phase == 4'd1) begin
            bus_scl = 1'b1;
            bus_phase = 4'd2;
          end else begin
            bus_ack = ~sda;
            bus_scl = 1'b0;
            fin = 1'b1;
          end
        end
        i2c_blm_pkg::CMD_READ: begin
          if (bus_bit < i2c_blm_pkg::BitsDone) begin
            if (bus_phase == 4'd0) begin
              bus_scl = 1'b1;
              bus_phase = 4'd1;
            end else begin
              bus_shift = {bus_shift[6:0], sda};
              bus_scl = 1'b0;
              bus_phase = 4'd0;
              bus_bit++;
            end
          end else if (bus_phase == 4'd0) begin
            bus_sda = 1'b0;
            bus_phase = 4'd1;
          end else if (bus_phase == 4'd1) begin
            bus_scl = 1'b1;
            bus_phase = 4'd2;
          end else if (bus_phase == 4'd2) begin
            bus_scl = 1'b0;
            bus_phase = 4'd3;
          end else begin
            bus_sda = 1'b1;
            bus_rx = bus_shift;
            fin = 1'b1;
          end
        end
        default: fin = 1'b1;
      endcase
      if (fin) begin
        bus_cmd = i2c_blm_pkg::CMD_NONE;
        bus_phase = 4'd0;
        bus_bit = 4'd0;
        bus_wait = 16'd0;
      end else begin
        bus_wait = step;
      end
    end
    r.scl_level = bus_scl;
    r.sda_level = bus_sda;
    r.busy_res = (bus_cmd != i2c_blm_pkg::CMD_NONE);
    r.done_res = fin;
    r.read_byte = bus_rx;
    r.ack_seen = bus_ack;
    return r;
  endfunction

  // mostly zero, sometimes short, now and then long
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 75) return 0;
    if (roll < 96) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic pick_sda(input sda_mode_e mode);
    case (mode)
      SDA_LOW: return 1'b0;
      SDA_HIGH: return 1'b1;
      default: return 1'($urandom);
    endcase
  endfunction

  // called at a falling edge, returns at a falling edge with valid possibly still high
  task automatic send_tick(input logic [2:0] op, input logic [7:0] data, input logic sda);
    int unsigned gap;
    in_if.valid <= 1'b1;
    in_if.opcode <= op;
    in_if.write_data <= data;
    in_if.sda_in <= sda;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    expected_beats.push_back(advance_bus(op, data, sda));
    ticks_sent++;
    @(negedge clk_i);
    gap = calm ? 0 : idle_len();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic wait_all_results();
    in_if.valid <= 1'b0;
    while (expected_beats.size() != 0) @(negedge clk_i);
  endtask

  task automatic run_command(input logic [2:0] op, input logic [7:0] data,
                             input sda_mode_e sda_mode, input fill_mode_e fill_mode);
    logic [2:0] fill_op;
    send_tick(op, data, pick_sda(sda_mode));
    while (bus_cmd != i2c_blm_pkg::CMD_NONE) begin
      case (fill_mode)
        FILL_NOISE: fill_op = 3'($urandom_range(7));
        FILL_READ: fill_op = i2c_blm_pkg::CMD_READ;
        default: fill_op = i2c_blm_pkg::CMD_NONE;
      endcase
      send_tick(fill_op, 8'($urandom), pick_sda(sda_mode));
    end
  endtask

  // register write only once the bus is idle and every beat is back
  task automatic program_half_period(input logic [15:0] value);
    while (bus_cmd != i2c_blm_pkg::CMD_NONE) begin
      send_tick(i2c_blm_pkg::CMD_NONE, 8'($urandom), 1'($urandom));
    end
    wait_all_results();
    repeat (3) @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    bus_half = value;
  endtask

  task automatic test_idle_ticks();
    send_tick(i2c_blm_pkg::CMD_NONE, 8'h00, 1'b0);
    send_tick(i2c_blm_pkg::CMD_NONE, 8'hFF, 1'b1);
    for (int k = 0; k < NumReserved; k++) begin
      send_tick(OpFirstReserved + 3'(k), (k % 2 == 0) ? 8'hFF : 8'h00, 1'(k));
    end
  endtask

  task automatic test_each_command();
    calm = 1'b1;
    run_command(i2c_blm_pkg::CMD_START, 8'h00, SDA_RANDOM, FILL_IDLE);
    run_command(i2c_blm_pkg::CMD_WRITE, 8'hFF, SDA_LOW, FILL_IDLE);
    run_command(i2c_blm_pkg::CMD_WRITE, 8'h00, SDA_HIGH, FILL_IDLE);
    calm = 1'b0;
    run_command(i2c_blm_pkg::CMD_READ, 8'h00, SDA_HIGH, FILL_IDLE);
    run_command(i2c_blm_pkg::CMD_READ, 8'hFF, SDA_LOW, FILL_IDLE);
    run_command(i2c_blm_pkg::CMD_READ, 8'h5A, SDA_RANDOM, FILL_IDLE);
    run_command(i2c_blm_pkg::CMD_STOP, 8'h00, SDA_RANDOM, FILL_IDLE);
    // commands offered on every busy tick, the completion tick among them
    run_command(i2c_blm_pkg::CMD_WRITE, 8'hA5, SDA_RANDOM, FILL_NOISE);
    run_command(i2c_blm_pkg::CMD_START, 8'h00, SDA_RANDOM, FILL_READ);
    run_command(i2c_blm_pkg::CMD_STOP, 8'h00, SDA_RANDOM, FILL_IDLE);
  endtask

  task automatic test_short_half_periods();
    // zero behaves like one
    program_half_period(16'h0000);
    run_command(i2c_blm_pkg::CMD_START, 8'h00, SDA_RANDOM, FILL_IDLE);
    run_command(i2c_blm_pkg::CMD_WRITE, 8'($urandom), SDA_RANDOM, FILL_IDLE);
    run_command(i2c_blm_pkg::CMD_READ, 8'h00, SDA_RANDOM, FILL_IDLE);
    run_command(i2c_blm_pkg::CMD_STOP, 8'h00, SDA_RANDOM, FILL_IDLE);
    program_half_period(16'h0001);
    run_command(i2c_blm_pkg::CMD_WRITE, 8'($urandom), SDA_RANDOM, FILL_NOISE);
    run_command(i2c_blm_pkg::CMD_READ, 8'h00, SDA_RANDOM, FILL_IDLE);
  endtask

  task automatic test_long_half_period();
    program_half_period(16'd48);
    calm = 1'b1;
    run_command(i2c_blm_pkg::CMD_START, 8'h00, SDA_RANDOM, FILL_IDLE);
    calm = 1'b0;
  endtask

  task automatic test_result_backpressure();
    program_half_period(16'h0001);
    // result side holds off long enough for the input to stall
    sink_hold = LongHold;
    calm = 1'b1;
    run_command(i2c_blm_pkg::CMD_WRITE, 8'($urandom), SDA_RANDOM, FILL_IDLE);
    run_command(i2c_blm_pkg::CMD_READ, 8'h00, SDA_RANDOM, FILL_IDLE);
    calm = 1'b0;
    wait_all_results();
    run_command(i2c_blm_pkg::CMD_STOP, 8'h00, SDA_RANDOM, FILL_IDLE);
    wait_all_results();
    run_command(i2c_blm_pkg::CMD_START, 8'h00, SDA_RANDOM, FILL_IDLE);
  endtask

  task automatic test_random_traffic();
    int unsigned start_ticks;
    int unsigned roll;
    int unsigned cmds;
    logic [15:0] half;
    start_ticks = ticks_sent;
    cmds = 0;
    while (ticks_sent - start_ticks < RandomTicks) begin
      if (cmds % 8 == 7) begin
        roll = $urandom_range(99);
        if (roll < 85) half = 16'($urandom_range(4));
        else half = 16'($urandom_range(20, 5));
        program_half_period(half);
      end
      calm = ($urandom_range(9) == 0);
      roll = $urandom_range(99);
      if (roll < 80) begin
        run_command(3'($urandom_range(i2c_blm_pkg::CMD_READ, i2c_blm_pkg::CMD_START)),
                    8'($urandom),
                    ($urandom_range(9) == 0) ? SDA_HIGH : SDA_RANDOM,
                    ($urandom_range(99) < 15) ? FILL_NOISE : FILL_IDLE);
      end else begin
        // noise burst, may start commands; the next command is then ignored and its fill ticks finish them
        repeat ($urandom_range(8, 1)) begin
          send_tick(3'($urandom_range(7)), 8'($urandom), 1'($urandom));
        end
      end
      cmds++;
    end
    calm = 1'b0;
  endtask

  // result side ready, random stalls and the long hold-off
  initial begin
    int unsigned left;
    left = 0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (sink_hold != 0) begin
        left = sink_hold;
        sink_hold = 0;
      end else if (left == 0 && !calm) begin
        left = idle_len();
      end
      if (left != 0) begin
        out_if.ready <= 1'b0;
        left--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    i2c_blm_pkg::res_t seen;
    i2c_blm_pkg::res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      seen.scl_level = out_if.scl_level;
      seen.sda_level = out_if.sda_level;
      seen.busy_res = out_if.busy_res;
      seen.done_res = out_if.done_res;
      seen.read_byte = out_if.read_byte;
      seen.ack_seen = out_if.ack_seen;
      if (expected_beats.size() == 0) begin
        bad_beats++;
        if (bad_beats <= MaxShown) $display("unexpected result beat: %p", seen);
      end else begin
        want = expected_beats.pop_front();
        if (seen !== want) begin
          bad_beats++;
          if (bad_beats <= MaxShown) begin
            $display("beat mismatch (exp/act): scl %b/%b sda %b/%b busy %b/%b done %b/%b",
                     want.scl_level, seen.scl_level, want.sda_level, seen.sda_level,
                     want.busy_res, seen.busy_res, want.done_res, seen.done_res);
            $display("  read_byte %h/%h ack_seen %b/%b", want.read_byte, seen.read_byte,
                     want.ack_seen, seen.ack_seen);
          end
        end
      end
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= StallLimit) begin
        $display("i2c_bit_level_master verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 16'h0000;
    in_if.valid = 1'b0;
    in_if.opcode = i2c_blm_pkg::CMD_NONE;
    in_if.write_data = 8'h00;
    in_if.sda_in = 1'b1;
    bus_half = i2c_blm_pkg::HalfPeriodReset;
    bus_cmd = i2c_blm_pkg::CMD_NONE;
    bus_phase = 4'd0;
    bus_bit = 4'd0;
    bus_shift = 8'h00;
    bus_wait = 16'd0;
    bus_scl = 1'b1;
    bus_sda = 1'b1;
    bus_rx = 8'h00;
    bus_ack = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_idle_ticks();
    test_each_command();
    test_short_half_periods();
    test_long_half_period();
    test_result_backpressure();
    test_random_traffic();

    wait_all_results();
    repeat (4) @(negedge clk_i);
    if (bad_beats == 0 && expected_beats.size() == 0) begin
      $display("i2c_bit_level_master verification clean");
    end else begin
      $display("i2c_bit_level_master verification failed");
    end
    $finish;
  end

endmodule
